// File: hdl/midpoint_circle_rasterizer_defines.svh
// Assertion helpers shared by the rasterizer RTL.
// Both sample on clk and stay quiet while arst_n is low.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_DEFINES_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_DEFINES_SVH

// Same-cycle implication.
`define MCR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MCR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/mcr_pkg.sv
package mcr_pkg;

	localparam int COORD_BITS_DEF = 10;

	localparam int PIX_W   = 12;
	localparam int COLOR_W = 8;
	localparam int OCT_W   = 3;
	localparam int STEP_W  = 10;
	localparam int DEC_W   = 13;
	localparam int CFG_W   = 11;
	localparam int IDX_W   = 1;

	localparam int M_TDATA_BITS = 2 * PIX_W + COLOR_W + OCT_W + STEP_W;
	localparam int M_TDATA_W    = ((M_TDATA_BITS + 7) / 8) * 8;
	localparam int M_TUSER_W    = 2;

	localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(640);
	localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(480);

	localparam logic [IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
	localparam logic [IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

	localparam logic ACT_START   = 1'b0;
	localparam logic ACT_ADVANCE = 1'b1;

	localparam logic [OCT_W-1:0] OCT_LAST = 3'd7;

	typedef struct packed {
		logic [CFG_W-1:0] width;
		logic [CFG_W-1:0] height;
	} scr_cfg_t;

endpackage

// File: hdl/mcr_front.sv
module mcr_front #(
	parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [((3*COORD_BITS+mcr_pkg::COLOR_W+7)/8)*8-1:0] s_tdata,
	input  logic                  s_tuser,
	output logic                  push,
	input  logic                  push_ready,
	output logic [4*COORD_BITS+mcr_pkg::COLOR_W+mcr_pkg::STEP_W:0] run_data
);
	localparam int CB    = COORD_BITS;
	localparam int DEC_W = mcr_pkg::DEC_W;

	logic [CB-1:0]                  cx_q, cy_q, x_q, y_q;
	logic [mcr_pkg::COLOR_W-1:0]    color_q;
	logic signed [DEC_W-1:0]        dec_q;
	logic [mcr_pkg::STEP_W-1:0]     cnt_q;
	logic                           active_q;

	logic                           acc, is_start;
	logic [CB-1:0]                  in_cx, in_cy, in_r;
	logic [mcr_pkg::COLOR_W-1:0]    in_col;
	logic [CB-1:0]                  x_inc, y_dec, x_n, y_n, cx_n, cy_n;
	logic [mcr_pkg::COLOR_W-1:0]    col_n;
	logic signed [DEC_W-1:0]        x_ext, y_ext, dec_n;
	logic [mcr_pkg::STEP_W-1:0]     step_n;
	logic                           done_n;

	assign s_tready = push_ready;
	assign acc      = s_tvalid && s_tready;
	assign is_start = (s_tuser == mcr_pkg::ACT_START);

	assign in_cx  = s_tdata[CB-1:0];
	assign in_cy  = s_tdata[2*CB-1:CB];
	assign in_r   = s_tdata[3*CB-1:2*CB];
	assign in_col = s_tdata[3*CB+mcr_pkg::COLOR_W-1:3*CB];

	assign x_inc = x_q + 1'b1;
	assign y_dec = y_q - 1'b1;

	always_comb begin
		x_ext = DEC_W'(x_inc);
		y_ext = DEC_W'(y_dec);
		if (is_start) begin
			cx_n   = in_cx;
			cy_n   = in_cy;
			col_n  = in_col;
			x_n    = '0;
			y_n    = in_r;
			dec_n  = DEC_W'(1) - DEC_W'(in_r);
			step_n = '0;
		end else begin
			cx_n   = cx_q;
			cy_n   = cy_q;
			col_n  = color_q;
			x_n    = x_inc;
			step_n = cnt_q;
			// midpoint step: negative decision keeps y
			if (dec_q[DEC_W-1]) begin
				y_n   = y_q;
				dec_n = dec_q + (x_ext <<< 1) + DEC_W'(1);
			end else begin
				y_n   = y_dec;
				dec_n = dec_q + ((x_ext - y_ext) <<< 1) - DEC_W'(1);
			end
		end
		done_n = !(x_n < y_n);
	end

	assign push     = acc && (is_start || active_q);
	assign run_data = {done_n, step_n, col_n, y_n, x_n, cy_n, cx_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			color_q  <= '0;
			x_q      <= '0;
			y_q      <= '0;
			dec_q    <= '0;
			cnt_q    <= '0;
			active_q <= 1'b0;
		end else if (push) begin
			cx_q     <= cx_n;
			cy_q     <= cy_n;
			color_q  <= col_n;
			x_q      <= x_n;
			y_q      <= y_n;
			dec_q    <= dec_n;
			cnt_q    <= step_n + 1'b1;
			active_q <= !done_n;
		end
	end

endmodule

// File: hdl/mcr_queue.sv
module mcr_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data
);
	// two-entry queue
	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/mcr_back.sv
module mcr_back #(
	parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            run_valid,
	output logic                            run_pop,
	input  logic [4*COORD_BITS+mcr_pkg::COLOR_W+mcr_pkg::STEP_W:0] run_data,
	input  mcr_pkg::scr_cfg_t               scr,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [mcr_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic [mcr_pkg::M_TUSER_W-1:0]   m_tuser,
	output logic                            m_tlast
);
	localparam int CB    = COORD_BITS;
	localparam int PW    = CB + 2;
	localparam int CW    = (PW > mcr_pkg::PIX_W) ? PW : mcr_pkg::PIX_W;
	localparam int RUN_W = 4 * CB + mcr_pkg::COLOR_W + mcr_pkg::STEP_W + 1;
	localparam int PAD_W = mcr_pkg::M_TDATA_W - mcr_pkg::M_TDATA_BITS;

	logic [RUN_W-1:0]           cur_q;
	logic [mcr_pkg::OCT_W-1:0]  oct_q;
	logic                       busy_q;
	logic                       out_valid_q;
	logic [mcr_pkg::M_TDATA_W-1:0] out_data_q;
	logic [mcr_pkg::M_TUSER_W-1:0] out_user_q;
	logic                       out_last_q;

	logic [CB-1:0]              cx, cy, a, b, dx, dy;
	logic [mcr_pkg::COLOR_W-1:0] col;
	logic [mcr_pkg::STEP_W-1:0] step;
	logic                       done;
	logic signed [PW-1:0]       px, py;
	logic signed [CW-1:0]       px_w, py_w;
	logic                       vis, adv, at_last;

	assign {done, step, col, b, a, cy, cx} = cur_q;

	// octant order: bit2 swaps the offsets, bit0 negates x, bit1 negates y
	assign dx = oct_q[2] ? b : a;
	assign dy = oct_q[2] ? a : b;

	always_comb begin
		px = oct_q[0] ? (PW'(cx) - PW'(dx)) : (PW'(cx) + PW'(dx));
		py = oct_q[1] ? (PW'(cy) - PW'(dy)) : (PW'(cy) + PW'(dy));
		px_w = CW'(px);
		py_w = CW'(py);
		vis = !px[PW-1] && !py[PW-1]
			&& ($unsigned(px_w) < CW'(scr.width))
			&& ($unsigned(py_w) < CW'(scr.height));
	end

	assign adv     = !out_valid_q || m_tready;
	assign at_last = (oct_q == mcr_pkg::OCT_LAST);
	assign run_pop = adv && run_valid && (!busy_q || at_last);

	always_ff @(posedge clk) begin
		if (run_pop) begin
			cur_q <= run_data;
		end
		if (adv && busy_q) begin
			out_data_q <= {PAD_W'(0), step, oct_q, col,
				py_w[mcr_pkg::PIX_W-1:0], px_w[mcr_pkg::PIX_W-1:0]};
			out_user_q <= {done, vis};
			out_last_q <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oct_q       <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= busy_q;
			if (run_pop) begin
				oct_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				oct_q <= oct_q + 1'b1;
				if (at_last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

endmodule

// File: hdl/midpoint_circle_rasterizer.sv
// Midpoint circle rasterizer, eight-way symmetric points per step.
// An accepted item goes through the run queue, the back end's run register and the output register.
// Throughput: eight points per run, one point per cycle unless m_tready stalls the output,
// set by the single point generator in the back end; a queued run follows the last with no gap.
// Reset (arst_n low, asynchronous): idle, no circle, queue empty, 640x480 screen.
`include "midpoint_circle_rasterizer_defines.svh"

module midpoint_circle_rasterizer #(
	parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration writes, no read-back
	input  logic                              cfg_we,
	input  logic [mcr_pkg::IDX_W-1:0]         cfg_index,
	input  logic [mcr_pkg::CFG_W-1:0]         cfg_data,
	// item in
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// center_x, center_y, radius, color, zero pad
	input  logic [((3*COORD_BITS+mcr_pkg::COLOR_W+7)/8)*8-1:0] s_tdata,
	// action: start or advance
	input  logic                              s_tuser,
	// points out
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// pixel_x, pixel_y, pixel_color, octant, step_index, zero pad
	output logic [mcr_pkg::M_TDATA_W-1:0]     m_tdata,
	// visible, circle_done
	output logic [mcr_pkg::M_TUSER_W-1:0]     m_tuser,
	// last_point
	output logic                              m_tlast
);
	localparam int RUN_W = 4 * COORD_BITS + mcr_pkg::COLOR_W + mcr_pkg::STEP_W + 1;

	// Front end holds the circle state and does one midpoint step per advance item.
	// Each start, or advance while drawing, pushes one run descriptor
	// (center, offsets, color, step number, done) into a two-entry queue.
	// An advance while idle is taken and dropped.
	// Back end pops a run and walks its eight octants into an output register.

	mcr_pkg::scr_cfg_t   scr_q;
	logic                q_push, q_ready, q_valid, q_pop;
	logic [RUN_W-1:0]    q_in, q_out;

	// screen size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_q.width  <= mcr_pkg::WIDTH_RST;
			scr_q.height <= mcr_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mcr_pkg::REG_SCREEN_WIDTH:  scr_q.width  <= cfg_data;
				mcr_pkg::REG_SCREEN_HEIGHT: scr_q.height <= cfg_data;
				default: ;
			endcase
		end
	end

	mcr_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push       (q_push),
		.push_ready (q_ready),
		.run_data   (q_in)
	);

	mcr_queue #(.WIDTH(RUN_W)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_ready (q_ready),
		.push_data  (q_in),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_data   (q_out)
	);

	mcr_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.run_valid (q_valid),
		.run_pop   (q_pop),
		.run_data  (q_out),
		.scr       (scr_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// queue must never be pushed while full or popped while empty
	`MCR_ASSERT_SAME(a_no_overflow, q_push, q_ready, "run queue overflow")
	`MCR_ASSERT_SAME(a_no_underflow, q_pop, q_valid, "run queue underflow")
	// tlast only on the eighth octant
	`MCR_ASSERT_SAME(a_last_octant, m_tvalid && m_tlast, m_tdata[34:32] == mcr_pkg::OCT_LAST, "tlast off octant 7")
	// a run leaves without gaps once started
	`MCR_ASSERT_NEXT(a_run_contig, m_tvalid && m_tready && !m_tlast, m_tvalid, "gap inside a run")

endmodule
